/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed: next-cycle consequence missing");

`endif

/* hw/rtl/dhfk_pkg.sv */
// ----------------------------------------------------------------------------
// dhfk_pkg
// Types, constants and helper functions of the forward kinematics block.
// ----------------------------------------------------------------------------
package dhfk_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COORD_BITS     = 24;
    localparam int LEN_BITS       = 18;
    localparam int CORDIC_ITERS   = 30;
    localparam int CORDIC_LAT     = CORDIC_ITERS + 2;
    localparam int BACK_LAT       = CORDIC_LAT + 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int RES_DEPTH      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_ARM    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FOREARM      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOOL_OFFSET  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ELBOW_OFFSET = 2'd3;

    localparam logic [LEN_BITS-1:0]   RST_UPPER_ARM    = 18'd52777;
    localparam logic [LEN_BITS-1:0]   RST_FOREARM      = 18'd51200;
    localparam logic [LEN_BITS-1:0]   RST_TOOL_OFFSET  = 18'h351DA; // -44582
    localparam logic [ANGLE_BITS-1:0] RST_ELBOW_OFFSET = ANGLE_BITS'(2505);

    typedef struct packed {
        logic [ANGLE_BITS-1:0] base_angle;
        logic [ANGLE_BITS-1:0] shoulder_angle;
        logic [ANGLE_BITS-1:0] elbow_angle;
        logic [ANGLE_BITS-1:0] wrist_pitch_angle;
        logic [ANGLE_BITS-1:0] wrist_roll_angle;
    } item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } result_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] t1;
        logic [ANGLE_BITS-1:0] t2;
        logic [ANGLE_BITS-1:0] t23;
        logic [ANGLE_BITS-1:0] t234;
    } joint_angles_t;

    typedef struct packed {
        logic [LEN_BITS-1:0]        upper_arm_length;
        logic [LEN_BITS-1:0]        forearm_length;
        logic signed [LEN_BITS-1:0] tool_offset;
        logic [ANGLE_BITS-1:0]      elbow_offset_angle;
    } cfg_t;

    typedef struct packed {
        logic advance;
        logic last_valid;
        logic busy;
    } back_stat_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        begin
            case (i)
                0:  r = 32'd536870912;
                1:  r = 32'd316933406;
                2:  r = 32'd167458907;
                3:  r = 32'd85004756;
                4:  r = 32'd42667331;
                5:  r = 32'd21354465;
                6:  r = 32'd10679838;
                7:  r = 32'd5340245;
                8:  r = 32'd2670163;
                9:  r = 32'd1335087;
                10: r = 32'd667544;
                11: r = 32'd333772;
                12: r = 32'd166886;
                13: r = 32'd83443;
                14: r = 32'd41722;
                15: r = 32'd20861;
                16: r = 32'd10430;
                17: r = 32'd5215;
                18: r = 32'd2608;
                19: r = 32'd1304;
                20: r = 32'd652;
                21: r = 32'd326;
                22: r = 32'd163;
                23: r = 32'd81;
                24: r = 32'd41;
                25: r = 32'd20;
                26: r = 32'd10;
                27: r = 32'd5;
                28: r = 32'd3;
                29: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            hi = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            if (v > hi)
            begin
                return hi[COORD_BITS-1:0];
            end
            else if (v < lo)
            begin
                return lo[COORD_BITS-1:0];
            end
            return v[COORD_BITS-1:0];
        end
    endfunction

endpackage

/* hw/rtl/dhfk_queue.sv */
// ----------------------------------------------------------------------------
// dhfk_queue
// Small register queue with full and empty flags, oldest entry shown first.
// ----------------------------------------------------------------------------
module dhfk_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [0:DEPTH-1];
    logic [PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

/* hw/rtl/dhfk_front.sv */
// ----------------------------------------------------------------------------
// dhfk_front
// Accepts joint angle requests and forms the four combined link angles.
// ----------------------------------------------------------------------------
module dhfk_front (
    input  logic                    push,
    input  logic                    full,
    input  dhfk_pkg::item_t         item,
    input  logic [dhfk_pkg::ANGLE_BITS-1:0] elbow_offset_angle,
    output logic                    q_push,
    output dhfk_pkg::joint_angles_t angles
);
    import dhfk_pkg::*;

    localparam logic [ANGLE_BITS-1:0] QUARTER  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF     = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER3 = HALF + QUARTER;

    logic [ANGLE_BITS-1:0] q23;

    // All angle sums wrap modulo one turn. Wrist roll does not move the tool tip.
    assign q23    = item.shoulder_angle + item.elbow_angle;
    assign q_push = push && !full;

    always_comb
    begin
        angles.t1   = item.base_angle - HALF;
        angles.t2   = item.shoulder_angle - QUARTER - elbow_offset_angle;
        angles.t23  = q23;
        angles.t234 = q23 + item.wrist_pitch_angle - QUARTER3;
    end

endmodule

/* hw/rtl/dhfk_cordic.sv */
// ----------------------------------------------------------------------------
// dhfk_cordic
// Pipelined rotation-mode CORDIC giving Q30 sine and cosine of a binary angle.
// ----------------------------------------------------------------------------
module dhfk_cordic (
    input  logic                            clk,
    input  logic                            en,
    input  logic [dhfk_pkg::ANGLE_BITS-1:0] angle,
    output logic signed [31:0]              sin_q30,
    output logic signed [31:0]              cos_q30
);
    import dhfk_pkg::*;

    logic signed [33:0] x_reg  [0:CORDIC_ITERS];
    logic signed [33:0] y_reg  [0:CORDIC_ITERS];
    logic signed [33:0] zz_reg [0:CORDIC_ITERS];
    logic               flip_reg [0:CORDIC_ITERS];
    logic signed [31:0] sin_reg, cos_reg;

    logic [31:0]        z32, z_sum, z_fold;
    logic               flip_next;
    logic signed [33:0] xo, yo;

    // Fold the angle into [-quarter, quarter) by a half-turn shift and later negation.
    always_comb
    begin
        z32       = {angle, {(32 - ANGLE_BITS){1'b0}}};
        z_sum     = z32 + 32'h4000_0000;
        flip_next = z_sum[31];
        z_fold    = flip_next ? (z32 + 32'h8000_0000) : z32;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            zz_reg[0]   <= {{2{z_fold[31]}}, z_fold};
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar k = 1; k <= CORDIC_ITERS; k++)
    begin : g_iter
        logic signed [33:0] x_next, y_next, zz_next;
        logic signed [33:0] atan_val;

        assign atan_val = $signed({2'b00, atan_turn(k - 1)});

        always_comb
        begin
            if (!zz_reg[k-1][33])
            begin
                x_next  = x_reg[k-1] - (y_reg[k-1] >>> (k - 1));
                y_next  = y_reg[k-1] + (x_reg[k-1] >>> (k - 1));
                zz_next = zz_reg[k-1] - atan_val;
            end
            else
            begin
                x_next  = x_reg[k-1] + (y_reg[k-1] >>> (k - 1));
                y_next  = y_reg[k-1] - (x_reg[k-1] >>> (k - 1));
                zz_next = zz_reg[k-1] + atan_val;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                zz_reg[k]   <= zz_next;
                flip_reg[k] <= flip_reg[k-1];
            end
        end
    end

    assign xo = flip_reg[CORDIC_ITERS] ? -x_reg[CORDIC_ITERS] : x_reg[CORDIC_ITERS];
    assign yo = flip_reg[CORDIC_ITERS] ? -y_reg[CORDIC_ITERS] : y_reg[CORDIC_ITERS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= xo[31:0];
            sin_reg <= yo[31:0];
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

/* hw/rtl/dhfk_back.sv */
// ----------------------------------------------------------------------------
// dhfk_back
// Sine/cosine units and the position datapath; stalls as a whole when the
// result queue is full.
// ----------------------------------------------------------------------------
module dhfk_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dhfk_pkg::cfg_t          cfg,
    input  logic                    in_valid,
    input  dhfk_pkg::joint_angles_t in_angles,
    output logic                    in_pop,
    input  logic                    res_full,
    output logic                    res_push,
    output dhfk_pkg::result_t       res_data,
    output dhfk_pkg::back_stat_t    stat
);
    import dhfk_pkg::*;

    logic                advance;
    logic [BACK_LAT-1:0] valid_reg;

    logic signed [31:0] s1, c1, s2, c2, s23, c23, s234, c234;

    logic signed [18:0] l2, l3;
    logic signed [50:0] p_uc2_reg, p_uc23_reg, p_us234_reg;
    logic signed [50:0] p_zs2_reg, p_zs23_reg, p_zc234_reg;
    logic signed [31:0] c1_a_reg, s1_a_reg, c1_b_reg, s1_b_reg;

    logic signed [52:0] u_sum, z_sum;
    logic signed [52:0] u_rnd, z_rnd;
    logic signed [29:0] u_reg;
    logic signed [22:0] z_reg, z_c_reg;

    logic signed [61:0] px_reg, py_reg;
    logic signed [61:0] x_rnd, y_rnd;
    result_t            res_reg;

    assign advance = !res_full;
    assign in_pop  = advance && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[BACK_LAT-2:0], in_pop};
        end
    end

    dhfk_cordic u_cordic_1 (
        .clk(clk), .en(advance), .angle(in_angles.t1), .sin_q30(s1), .cos_q30(c1)
    );
    dhfk_cordic u_cordic_2 (
        .clk(clk), .en(advance), .angle(in_angles.t2), .sin_q30(s2), .cos_q30(c2)
    );
    dhfk_cordic u_cordic_23 (
        .clk(clk), .en(advance), .angle(in_angles.t23), .sin_q30(s23), .cos_q30(c23)
    );
    dhfk_cordic u_cordic_234 (
        .clk(clk), .en(advance), .angle(in_angles.t234), .sin_q30(s234), .cos_q30(c234)
    );

    assign l2 = $signed({1'b0, cfg.upper_arm_length});
    assign l3 = $signed({1'b0, cfg.forearm_length});

    // Link products, Q38.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_uc2_reg   <= l2 * c2;
            p_uc23_reg  <= l3 * c23;
            p_us234_reg <= cfg.tool_offset * s234;
            p_zs2_reg   <= l2 * s2;
            p_zs23_reg  <= l3 * s23;
            p_zc234_reg <= cfg.tool_offset * c234;
            c1_a_reg    <= c1;
            s1_a_reg    <= s1;
        end
    end

    always_comb
    begin
        u_sum = 53'(p_uc2_reg) + 53'(p_uc23_reg) + 53'(p_us234_reg);
        z_sum = 53'(p_zs2_reg) + 53'(p_zs23_reg) - 53'(p_zc234_reg);
        u_rnd = (u_sum + (53'sd1 <<< 21)) >>> 22;
        z_rnd = (z_sum + (53'sd1 <<< 29)) >>> 30;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            u_reg    <= u_rnd[29:0];
            z_reg    <= z_rnd[22:0];
            c1_b_reg <= c1_a_reg;
            s1_b_reg <= s1_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg  <= u_reg * c1_b_reg;
            py_reg  <= u_reg * s1_b_reg;
            z_c_reg <= z_reg;
        end
    end

    assign x_rnd = (px_reg + (62'sd1 <<< 37)) >>> 38;
    assign y_rnd = (py_reg + (62'sd1 <<< 37)) >>> 38;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.pos_x <= sat_coord(64'(x_rnd));
            res_reg.pos_y <= sat_coord(64'(y_rnd));
            res_reg.pos_z <= sat_coord(64'(z_c_reg));
        end
    end

    assign res_push        = advance && valid_reg[BACK_LAT-1];
    assign res_data        = res_reg;
    assign stat.advance    = advance;
    assign stat.last_valid = valid_reg[BACK_LAT-1];
    assign stat.busy       = |valid_reg;

endmodule

/* hw/rtl/dh_forward_kinematics_5dof.sv */
// ----------------------------------------------------------------------------
// dh_forward_kinematics_5dof
// Five-joint arm forward kinematics: joint angles in, tool tip position out.
// ----------------------------------------------------------------------------
// Requests are written like a queue: an item is taken when push is high and
// full is low. Results are read like a queue: while empty is low the oldest
// position is on result, and pop takes it. Configuration registers are written
// over cfg_valid/cfg_index/cfg_data; cfg_ready is always high, and writes
// belong to times when no request is in flight.
// A request enters a small queue, then a pipeline of four CORDIC units (one
// step per stage) and four multiply/round stages before it reaches the
// result queue. One request is taken per cycle while the pipeline is not
// stalled; the CORDIC stage count sets most of the latency.
// When the reader stalls, the pipeline freezes once the result queue is full,
// and the request queue then fills and raises full. Reset empties both queues,
// clears the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dh_forward_kinematics_5dof #(
    parameter int QUEUE_DEPTH = dhfk_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  dhfk_pkg::item_t                     item,
    output logic                                empty,
    input  logic                                pop,
    output dhfk_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dhfk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dhfk_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import dhfk_pkg::*;

    cfg_t          cfg_reg;
    joint_angles_t front_angles, mid_angles;
    logic          mid_push, mid_pop, mid_empty;
    logic          res_push, res_full;
    result_t       res_data;
    back_stat_t    bstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_arm_length   <= RST_UPPER_ARM;
            cfg_reg.forearm_length     <= RST_FOREARM;
            cfg_reg.tool_offset        <= $signed(RST_TOOL_OFFSET);
            cfg_reg.elbow_offset_angle <= RST_ELBOW_OFFSET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_UPPER_ARM:    cfg_reg.upper_arm_length   <= cfg_data[LEN_BITS-1:0];
                REG_FOREARM:      cfg_reg.forearm_length     <= cfg_data[LEN_BITS-1:0];
                REG_TOOL_OFFSET:  cfg_reg.tool_offset        <= $signed(cfg_data[LEN_BITS-1:0]);
                REG_ELBOW_OFFSET: cfg_reg.elbow_offset_angle <= cfg_data[ANGLE_BITS-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    dhfk_front u_front (
        .push(push),
        .full(full),
        .item(item),
        .elbow_offset_angle(cfg_reg.elbow_offset_angle),
        .q_push(mid_push),
        .angles(front_angles)
    );

    dhfk_queue #(
        .WIDTH($bits(joint_angles_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_mid_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(mid_push),
        .wdata(front_angles),
        .full(full),
        .pop(mid_pop),
        .rdata(mid_angles),
        .empty(mid_empty)
    );

    dhfk_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .in_valid(!mid_empty),
        .in_angles(mid_angles),
        .in_pop(mid_pop),
        .res_full(res_full),
        .res_push(res_push),
        .res_data(res_data),
        .stat(bstat)
    );

    dhfk_queue #(
        .WIDTH($bits(result_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(res_push),
        .wdata(res_data),
        .full(res_full),
        .pop(pop),
        .rdata(result),
        .empty(empty)
    );

    `ASSERT_NEVER(a_res_no_overflow, clk, rst_n, res_push && res_full)
    `ASSERT_NEVER(a_mid_no_underflow, clk, rst_n, mid_pop && mid_empty)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, !bstat.advance, $stable(bstat.last_valid))
    `ASSERT_NEVER(a_push_needs_valid, clk, rst_n, res_push && !bstat.busy)

endmodule
